### src/sprite_sheet_frame_animator_top_assert.svh
// Assertion macros for the sprite sheet frame animator.
// Expects a clock named clk and an active low reset named arst_n in scope.
`ifndef SPRITE_SHEET_FRAME_ANIMATOR_TOP_ASSERT_SVH
`define SPRITE_SHEET_FRAME_ANIMATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define SSFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ssfa_pkg.sv
// Shared types and constants of the sprite sheet frame animator.
// Used by every module of the block; depends on nothing.
package ssfa_pkg;

	localparam int FRAME_INDEX_BITS = 8;
	localparam int DIM_W = 12;
	localparam int LIN_W = FRAME_INDEX_BITS + DIM_W;
	localparam int DIV_CNT_W = $clog2(LIN_W);
	localparam int FCMP_W = (FRAME_INDEX_BITS + 1 > 8) ? FRAME_INDEX_BITS + 1 : 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [FRAME_INDEX_BITS-1:0] frame_t;
	typedef logic [FRAME_INDEX_BITS:0] frame_inc_t;
	typedef logic [FCMP_W-1:0] fcmp_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [LIN_W-1:0] lin_t;
	typedef logic [DIM_W+LIN_W-1:0] prod_t;
	typedef logic signed [15:0] pos_t;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_SELECT  = 2'd1,
		KIND_SET_POS = 2'd2,
		KIND_RENDER  = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_COUNT     = 3'd0,
		REG_TICKS_PER_FRAME = 3'd1,
		REG_FRAME_WIDTH     = 3'd2,
		REG_FRAME_HEIGHT    = 3'd3,
		REG_SHEET_WIDTH     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  frame_count;
		logic [15:0] ticks_per_frame;
		dim_t        frame_width;
		dim_t        frame_height;
		dim_t        sheet_width;
	} cfg_t;

	typedef struct packed {
		frame_t frame;
		pos_t   pos_x;
		pos_t   pos_y;
	} item_t;

endpackage

### src/sprite_sheet_frame_animator_top.sv
// Each item passes the queue, then the back part's multiply, bit-serial divide (one
// bit per cycle of the 20-bit sheet offset by the sheet width) and scale; the back part
// takes no new item until idle again, and the front takes up to four items ahead.
// Reset clears the animation state and queue, and sets every config register to 1.
// No clearing pass is needed after reset.
`include "sprite_sheet_frame_animator_top_assert.svh"

module sprite_sheet_frame_animator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ssfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ssfa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         kind,
	input  logic [7:0]                         frame_value,
	input  logic signed [15:0]                 new_x,
	input  logic signed [15:0]                 new_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         frame_index,
	output logic [11:0]                        source_x,
	output logic [31:0]                        source_y,
	output logic signed [15:0]                 dest_x,
	output logic signed [15:0]                 dest_y
);

	ssfa_pkg::cfg_t   cfg_q;
	ssfa_pkg::item_t  push_item, head_item;
	logic             push, pop, q_full, q_empty;
	logic             sel_push;
	ssfa_pkg::frame_t sel_frame;

	assign sel_push = push && (kind == ssfa_pkg::KIND_SELECT);
	assign sel_frame = ssfa_pkg::frame_t'(frame_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= 8'd1;
			cfg_q.ticks_per_frame <= 16'd1;
			cfg_q.frame_width <= 12'd1;
			cfg_q.frame_height <= 12'd1;
			cfg_q.sheet_width <= 12'd1;
		end else if (cfg_wr_en) begin
			case (ssfa_pkg::cfg_reg_t'(cfg_index))
				ssfa_pkg::REG_FRAME_COUNT: cfg_q.frame_count <= cfg_wdata[7:0];
				ssfa_pkg::REG_TICKS_PER_FRAME: cfg_q.ticks_per_frame <= cfg_wdata;
				ssfa_pkg::REG_FRAME_WIDTH: cfg_q.frame_width <= cfg_wdata[11:0];
				ssfa_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata[11:0];
				ssfa_pkg::REG_SHEET_WIDTH: cfg_q.sheet_width <= cfg_wdata[11:0];
				default: begin
				end
			endcase
		end
	end

	ssfa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.frame_value (frame_value),
		.new_x       (new_x),
		.new_y       (new_y),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	ssfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	ssfa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_index (frame_index),
		.source_x    (source_x),
		.source_y    (source_y),
		.dest_x      (dest_x),
		.dest_y      (dest_y)
	);

	`SSFA_ASSERT_IMP(a_no_push_when_full, push, !q_full, "Queue written while full.")
	`SSFA_ASSERT_IMP(a_no_pop_when_empty, pop, !q_empty, "Queue read while empty.")
	`SSFA_ASSERT_IMP(a_select_snapshot, sel_push, push_item.frame == sel_frame, "Frame lost.")

endmodule

### src/ssfa_front.sv
// Front part: accepts input items, updates the animation state and
// queues a snapshot of it per item. Depends on ssfa_pkg.
module ssfa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssfa_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [7:0]           frame_value,
	input  logic signed [15:0]   new_x,
	input  logic signed [15:0]   new_y,
	input  logic                 q_full,
	output logic                 push,
	output ssfa_pkg::item_t      push_item
);

	logic [15:0]         tick_q, tick_d, tick_inc;
	ssfa_pkg::frame_t    frame_q, frame_d;
	ssfa_pkg::frame_inc_t frame_inc;
	ssfa_pkg::pos_t      pos_x_q, pos_y_q, pos_x_d, pos_y_d;
	logic                wrap;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;

	always_comb begin
		tick_inc = tick_q + 16'd1;
		frame_inc = ssfa_pkg::frame_inc_t'(frame_q) + ssfa_pkg::frame_inc_t'(1);
		wrap = frame_inc[ssfa_pkg::FRAME_INDEX_BITS] ||
			(ssfa_pkg::fcmp_t'(frame_inc) >= ssfa_pkg::fcmp_t'(cfg.frame_count));
		tick_d = tick_q;
		frame_d = frame_q;
		pos_x_d = pos_x_q;
		pos_y_d = pos_y_q;
		case (kind)
			ssfa_pkg::KIND_TICK: begin
				if (tick_inc >= cfg.ticks_per_frame) begin
					tick_d = 16'd0;
					frame_d = wrap ? '0 : ssfa_pkg::frame_t'(frame_inc);
				end else begin
					tick_d = tick_inc;
				end
			end
			ssfa_pkg::KIND_SELECT: begin
				frame_d = ssfa_pkg::frame_t'(frame_value);
			end
			ssfa_pkg::KIND_SET_POS: begin
				pos_x_d = new_x;
				pos_y_d = new_y;
			end
			default: begin
			end
		endcase
		push_item.frame = frame_d;
		push_item.pos_x = pos_x_d;
		push_item.pos_y = pos_y_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			frame_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (push) begin
			tick_q <= tick_d;
			frame_q <= frame_d;
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
		end
	end

endmodule

### src/ssfa_queue.sv
// Short queue of state snapshots between the front and back parts.
// Depends on ssfa_pkg for the entry type and depth.
module ssfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssfa_pkg::item_t push_item,
	input  logic            pop,
	output ssfa_pkg::item_t head_item,
	output logic            full,
	output logic            empty
);

	ssfa_pkg::item_t                 mem_q [ssfa_pkg::QUEUE_DEPTH];
	logic [ssfa_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [ssfa_pkg::QCNT_W-1:0]     count_q;

	assign full = (count_q == ssfa_pkg::QCNT_W'(ssfa_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ssfa_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ssfa_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ssfa_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ssfa_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

### src/ssfa_back.sv
// Back part: turns a queued frame into its sheet origin with a multiply,
// a bit-serial divide and a scale, then holds the result item. Uses ssfa_pkg.
module ssfa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ssfa_pkg::cfg_t     cfg,
	input  logic               q_empty,
	input  ssfa_pkg::item_t    head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         frame_index,
	output logic [11:0]        source_x,
	output logic [31:0]        source_y,
	output logic signed [15:0] dest_x,
	output logic signed [15:0] dest_y
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SCALE,
		ST_DONE
	} state_t;

	state_t                         state_q;
	ssfa_pkg::item_t                item_q;
	ssfa_pkg::lin_t                 lin_q;
	ssfa_pkg::dim_t                 div_q, rem_q, rem_next;
	logic [ssfa_pkg::DIM_W:0]       rem_shift;
	logic                           ge;
	logic [ssfa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [31:0]                    sy_q;
	ssfa_pkg::prod_t                prod;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		rem_shift = {rem_q, lin_q[ssfa_pkg::LIN_W-1]};
		ge = rem_shift >= {1'b0, div_q};
		rem_next = ge ? ssfa_pkg::DIM_W'(rem_shift - {1'b0, div_q})
			: ssfa_pkg::DIM_W'(rem_shift);
		prod = ssfa_pkg::prod_t'(cfg.frame_height) * ssfa_pkg::prod_t'(lin_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						item_q <= head_item;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					lin_q <= ssfa_pkg::lin_t'(item_q.frame) *
						ssfa_pkg::lin_t'(cfg.frame_width);
					div_q <= (cfg.sheet_width == '0) ? ssfa_pkg::dim_t'(1) : cfg.sheet_width;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					lin_q <= {lin_q[ssfa_pkg::LIN_W-2:0], ge};
					cnt_q <= cnt_q + ssfa_pkg::DIV_CNT_W'(1);
					if (cnt_q == ssfa_pkg::DIV_CNT_W'(ssfa_pkg::LIN_W - 1)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					sy_q <= 32'(prod);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						frame_index <= 8'(item_q.frame);
						source_x <= rem_q;
						source_y <= sy_q;
						dest_x <= item_q.pos_x;
						dest_y <= item_q.pos_y;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/ssfa_checker.sv
// Checker for the sprite sheet frame animator: it follows register writes, predicts the
// result of every accepted item and compares each accepted result in order.
// Depends on ssfa_pkg for kinds, register indexes and field types.
module ssfa_checker
	import ssfa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [1:0]             kind,
	input  logic [7:0]             frame_value,
	input  logic signed [15:0]     new_x,
	input  logic signed [15:0]     new_y,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [7:0]             frame_index,
	input  logic [11:0]            source_x,
	input  logic [31:0]            source_y,
	input  logic signed [15:0]     dest_x,
	input  logic signed [15:0]     dest_y,
	output int                     mismatches,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  frame;
		logic [11:0] src_x;
		logic [31:0] src_y;
		logic [15:0] dst_x;
		logic [15:0] dst_y;
	} sprite_view_t;

	logic [7:0]  frame_cnt;
	logic [15:0] ticks_pf;
	logic [11:0] frame_w;
	logic [11:0] frame_h;
	logic [11:0] sheet_w;

	logic [15:0] tick_cnt;
	logic [7:0]  cur_frame;
	logic [15:0] pos_x;
	logic [15:0] pos_y;

	sprite_view_t due_views[$];
	int           fail_cnt;

	function automatic sprite_view_t next_view(input kind_t k, input logic [7:0] fv,
						   input logic [15:0] x, input logic [15:0] y);
		logic [8:0]   nxt;
		logic [19:0]  linear;
		logic [11:0]  divisor;
		sprite_view_t v;
		case (k)
			KIND_TICK: begin
				tick_cnt = tick_cnt + 16'd1;
				if (tick_cnt >= ticks_pf) begin
					nxt = {1'b0, cur_frame} + 9'd1;
					if (nxt >= {1'b0, frame_cnt} || nxt[8])
						nxt = 9'd0;
					cur_frame = nxt[7:0];
					tick_cnt = 16'd0;
				end
			end
			KIND_SELECT: cur_frame = fv;
			KIND_SET_POS: begin
				pos_x = x;
				pos_y = y;
			end
			default: ;
		endcase
		linear = cur_frame * frame_w;
		divisor = (sheet_w == 12'd0) ? 12'd1 : sheet_w;
		v.frame = cur_frame;
		v.src_x = 12'(linear % divisor);
		v.src_y = 32'(frame_h) * 32'(linear / divisor);
		v.dst_x = pos_x;
		v.dst_y = pos_y;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sprite_view_t want;
		if (!arst_n) begin
			frame_cnt = 8'd1;
			ticks_pf = 16'd1;
			frame_w = 12'd1;
			frame_h = 12'd1;
			sheet_w = 12'd1;
			tick_cnt = 16'd0;
			cur_frame = 8'd0;
			pos_x = 16'd0;
			pos_y = 16'd0;
			due_views.delete();
			fail_cnt = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_COUNT:     frame_cnt = cfg_wdata[7:0];
					REG_TICKS_PER_FRAME: ticks_pf = cfg_wdata;
					REG_FRAME_WIDTH:     frame_w = cfg_wdata[11:0];
					REG_FRAME_HEIGHT:    frame_h = cfg_wdata[11:0];
					REG_SHEET_WIDTH:     sheet_w = cfg_wdata[11:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_views.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("ERROR: unexpected result frame=%0d sx=%0d sy=%0d dx=%0d dy=%0d",
							 frame_index, source_x, source_y, dest_x, dest_y);
				end else begin
					want = due_views.pop_front();
					if (frame_index !== want.frame || source_x !== want.src_x ||
					    source_y !== want.src_y || dest_x !== want.dst_x ||
					    dest_y !== want.dst_y) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("ERROR: expected frame=%0d sx=%0d sy=%0d dx=%0d dy=%0d",
								 want.frame, want.src_x, want.src_y,
								 $signed(want.dst_x), $signed(want.dst_y));
							$display("       got      frame=%0d sx=%0d sy=%0d dx=%0d dy=%0d",
								 frame_index, source_x, source_y, dest_x, dest_y);
						end
					end
				end
			end
			if (in_valid && in_ready)
				due_views.push_back(next_view(kind_t'(kind), frame_value, new_x, new_y));
			pending <= due_views.size();
			mismatches <= fail_cnt;
		end
	end

endmodule

### tb/sprite_sheet_frame_animator_top_tb.sv
// Testbench top for the sprite sheet frame animator: clock, reset, register writes,
// directed and random items with random idling on both channels, and the verdict.
// Depends on ssfa_pkg, the block itself and the checker in ssfa_checker.sv.
module sprite_sheet_frame_animator_top_tb
	import ssfa_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             kind;
	logic [7:0]             frame_value;
	logic signed [15:0]     new_x;
	logic signed [15:0]     new_y;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [7:0]             frame_index;
	logic [11:0]            source_x;
	logic [31:0]            source_y;
	logic signed [15:0]     dest_x;
	logic signed [15:0]     dest_y;

	int mismatches;
	int pending;
	int idle_odds = 3;
	int stall_left = 0;

	sprite_sheet_frame_animator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .frame_value(frame_value), .new_x(new_x), .new_y(new_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_index(frame_index), .source_x(source_x), .source_y(source_y),
		.dest_x(dest_x), .dest_y(dest_y)
	);

	ssfa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .frame_value(frame_value), .new_x(new_x), .new_y(new_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_index(frame_index), .source_x(source_x), .source_y(source_y),
		.dest_x(dest_x), .dest_y(dest_y),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_odds == 0) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(1, idle_odds) == 1) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(input kind_t k, input logic [7:0] fv,
				 input logic [15:0] x, input logic [15:0] y);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		frame_value <= fv;
		new_x <= x;
		new_y <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] fc, input logic [15:0] tpf,
				  input logic [11:0] fw, input logic [11:0] fh,
				  input logic [11:0] sw);
		drain();
		write_reg(REG_FRAME_COUNT, 16'(fc));
		write_reg(REG_TICKS_PER_FRAME, tpf);
		write_reg(REG_FRAME_WIDTH, 16'(fw));
		write_reg(REG_FRAME_HEIGHT, 16'(fh));
		write_reg(REG_SHEET_WIDTH, 16'(sw));
	endtask

	// Half ticks so that frames advance and wrap; unused fields carry noise.
	task automatic send_random(input logic [7:0] fc);
		int          r;
		logic [7:0]  fv;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0 || fc == 8'd0)
			fv = 8'($urandom);
		else
			fv = 8'($urandom_range(0, fc - 1));
		if (r < 50)
			send_item(KIND_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
		else if (r < 65)
			send_item(KIND_SELECT, fv, 16'($urandom), 16'($urandom));
		else if (r < 80)
			send_item(KIND_SET_POS, 8'($urandom), 16'($urandom), 16'($urandom));
		else
			send_item(KIND_RENDER, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		logic [7:0]  fc;
		logic [15:0] tpf;
		logic [11:0] fw;
		logic [11:0] fh;
		logic [11:0] sw;
		in_valid <= 1'b0;
		kind <= KIND_TICK;
		frame_value <= 8'd0;
		new_x <= 16'sd0;
		new_y <= 16'sd0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_FRAME_COUNT;
		cfg_wdata <= 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a single frame, one pixel wide.
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		send_item(KIND_SET_POS, 8'd0, 16'h8000, 16'h7FFF);
		send_item(KIND_SET_POS, 8'd0, 16'h7FFF, 16'h8000);
		send_item(KIND_SELECT, 8'd255, 16'd0, 16'd0);
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);

		// Lowering the tick threshold below the running count advances at once.
		set_config(8'd4, 16'd3, 12'd100, 12'd50, 12'd250);
		send_item(KIND_SELECT, 8'd2, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		drain();
		write_reg(REG_TICKS_PER_FRAME, 16'd1);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		send_item(KIND_SELECT, 8'd255, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		send_item(KIND_SET_POS, 8'd0, 16'd0, 16'hFFFF);
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);

		// Zero frame count, zero threshold and zero sheet width, then zero frame size.
		set_config(8'd0, 16'd0, 12'd7, 12'd3, 12'd0);
		send_item(KIND_SELECT, 8'd200, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);
		set_config(8'd9, 16'd0, 12'd0, 12'd0, 12'd5);
		send_item(KIND_SELECT, 8'd9, 16'd0, 16'd0);
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);

		set_config(8'd255, 16'd65535, 12'd4095, 12'd4095, 12'd1);
		send_item(KIND_SELECT, 8'd254, 16'd0, 16'd0);
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);
		send_item(KIND_TICK, 8'd0, 16'd0, 16'd0);
		set_config(8'd255, 16'd65535, 12'd4095, 12'd4095, 12'd4095);
		send_item(KIND_RENDER, 8'd0, 16'd0, 16'd0);

		for (int phase = 0; phase < 7; phase++) begin
			fc = 8'($urandom_range(1, 255));
			tpf = 16'($urandom_range(0, 4));
			fw = 12'($urandom_range(1, 4095));
			fh = 12'($urandom_range(1, 4095));
			sw = 12'($urandom_range(1, 4095));
			idle_odds = 4;
			case (phase)
				0: fc = 8'($urandom_range(1, 16));
				1: begin
					fc = 8'd255;
					tpf = 16'd0;
					fw = 12'd4095;
					fh = 12'd4095;
					sw = 12'd4095;
				end
				2: begin
					fc = 8'd1;
					tpf = 16'd1;
					fw = 12'd1;
					fh = 12'd1;
					sw = 12'd1;
					idle_odds = 2;
				end
				3: sw = 12'($urandom_range(1, 64));
				4: begin
					tpf = 16'($urandom);
					idle_odds = 0;
				end
				5: begin
					fc = 8'($urandom_range(2, 40));
					tpf = 16'($urandom_range(1, 6));
					sw = 12'd4095;
				end
				default: idle_odds = 0;
			endcase
			set_config(fc, tpf, fw, fh, sw);
			repeat (100) send_random(fc);
		end

		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/ssfa_pkg.sv
src/ssfa_front.sv
src/ssfa_queue.sv
src/ssfa_back.sv
src/sprite_sheet_frame_animator_top.sv
tb/ssfa_checker.sv
tb/sprite_sheet_frame_animator_top_tb.sv
